>>> design/hpd_pkg.sv
// HPACK Huffman decoder package: item type, canonical code tables.
// Tables are built at elaboration from the RFC 7541 code length list.
// No dependencies.
package hpd_pkg;

  localparam int SYM_COUNT     = 257;
  localparam int MAX_CODE_BITS = 30;
  localparam int BYTE_W        = 8;
  localparam int SYM_W         = 9;
  localparam int LEN_W         = 5;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int LEN_DEPTH     = 2 ** LEN_W;
  localparam int SORT_DEPTH    = SYM_COUNT - 1;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SYM_W-1:0]  sym_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              final_flag;
  } hpd_item_t;

  typedef len_t  len_tab_t  [SYM_COUNT];
  typedef code_t code_tab_t [LEN_DEPTH];
  typedef sym_t  cnt_tab_t  [LEN_DEPTH];
  typedef sym_t  sort_tab_t [SORT_DEPTH];

  localparam len_tab_t CODE_LEN = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
    30
  };

  // number of codes of each length
  function automatic cnt_tab_t calc_len_cnt();
    cnt_tab_t tab;
    for (int l = 0; l < LEN_DEPTH; l++) begin
      tab[l] = '0;
    end
    for (int s = 0; s < SYM_COUNT; s++) begin
      tab[CODE_LEN[s]] = tab[CODE_LEN[s]] + sym_t'(1);
    end
    tab[0] = '0;
    return tab;
  endfunction

  localparam cnt_tab_t LEN_CNT = calc_len_cnt();

  // first (numerically smallest) code of each length
  function automatic code_tab_t calc_first_code();
    code_tab_t          tab;
    logic [CODE_W+1:0]  code;
    code = '0;
    for (int l = 0; l < LEN_DEPTH; l++) begin
      tab[l] = '0;
    end
    for (int l = 1; l <= MAX_CODE_BITS; l++) begin
      tab[l] = code[CODE_W-1:0];
      code   = (code + (CODE_W+2)'(LEN_CNT[l])) << 1;
    end
    return tab;
  endfunction

  localparam code_tab_t FIRST_CODE = calc_first_code();

  // position in the length-sorted symbol list of the first code of each length
  function automatic cnt_tab_t calc_base_idx();
    cnt_tab_t tab;
    sym_t     acc;
    acc = '0;
    for (int l = 0; l < LEN_DEPTH; l++) begin
      tab[l] = acc;
      acc    = acc + LEN_CNT[l];
    end
    return tab;
  endfunction

  localparam cnt_tab_t BASE_IDX = calc_base_idx();

  // symbols sorted by code length then value; EOS sorts last and is left out
  function automatic sort_tab_t calc_sorted_sym();
    sort_tab_t tab;
    int        k;
    k = 0;
    for (int i = 0; i < SORT_DEPTH; i++) begin
      tab[i] = '0;
    end
    for (int l = 1; l <= MAX_CODE_BITS; l++) begin
      for (int s = 0; s < SYM_COUNT; s++) begin
        if (CODE_LEN[s] == len_t'(l) && k < SORT_DEPTH) begin
          tab[k] = sym_t'(s);
          k      = k + 1;
        end
      end
    end
    return tab;
  endfunction

  localparam sort_tab_t SORTED_SYM = calc_sorted_sym();

endpackage

>>> design/hpack_huffman_decoder.sv
// HPACK Huffman string decoder: two-entry request queue in front of a bit-serial code walk.
// Each byte is registered in the queue, then taken into the walk's byte register and walked
// bit by bit from the MSB; each symbol, and the closing item of a final byte, is registered
// in the result register. The queue can take new bytes while the walk is busy, and a held
// output stalls the walk. Sync reset empties the queue and clears the walk.
module hpack_huffman_decoder
  import hpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              final_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  symbol,
  output logic              symbol_valid,
  output logic              end_of_string,
  output logic [LEN_W-1:0]  leftover_bits
);

  logic       q_valid;
  hpd_item_t  q_item;
  logic       q_pop;
  len_t       walk_len;

  hpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  hpd_walk u_walk (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .symbol        (symbol),
    .symbol_valid  (symbol_valid),
    .end_of_string (end_of_string),
    .leftover_bits (leftover_bits),
    .walk_len      (walk_len)
  );

  // the code is complete, so a partial code never reaches the longest length
  assert property (@(posedge clk) disable iff (rst)
    walk_len < len_t'(MAX_CODE_BITS))
    else $error("partial code too long");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && symbol_valid) |->
      (!end_of_string && leftover_bits == '0 && symbol <= sym_t'(SYM_COUNT - 1)))
    else $error("bad symbol request");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full but nothing to pop");

  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> design/hpd_queue.sv
// Front end: takes encoded bytes and holds them in a two-entry queue.
// Depends on hpd_pkg.
module hpd_queue
  import hpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              final_byte,
  output logic              q_valid,
  output hpd_item_t         q_item,
  input  logic              q_pop
);

  hpd_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data: data_byte, final_flag: final_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/hpd_walk.sv
// Back end: bit-serial canonical Huffman walk, one encoded bit per cycle unless a held
// result stalls it, with the result register. Depends on hpd_pkg.
module hpd_walk
  import hpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  hpd_item_t         q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SYM_W-1:0]  symbol,
  output logic              symbol_valid,
  output logic              end_of_string,
  output logic [LEN_W-1:0]  leftover_bits,
  output logic [LEN_W-1:0]  walk_len
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BITS  = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;

  localparam logic [2:0] LAST_BIT = 3'(BYTE_W - 1);

  logic [1:0]  state;
  hpd_item_t   cur;
  logic [2:0]  bit_idx;
  code_t       code_acc;
  len_t        code_len;

  logic        bit_in;
  code_t       code_next;
  len_t        len_next;
  logic [CODE_W:0] sub;
  logic        hit;
  sym_t        sort_idx;
  sym_t        hit_sym;
  logic        out_free;
  logic        advance;
  logic        last;
  logic        close_go;
  logic        out_load;

  assign walk_len = code_len;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    bit_in    = cur.data[LAST_BIT - bit_idx];
    code_next = {code_acc[CODE_W-2:0], bit_in};
    len_next  = code_len + len_t'(1);
    sub       = {1'b0, code_next} - {1'b0, FIRST_CODE[len_next]};
    // codes of one length are consecutive from the first code of that length
    hit       = !sub[CODE_W] && (sub[CODE_W-1:0] < code_t'(LEN_CNT[len_next]));
    sort_idx  = BASE_IDX[len_next] + sub[SYM_W-1:0];
    hit_sym   = sort_idx[SYM_W-1] ? sym_t'(SYM_COUNT - 1)
                                  : SORTED_SYM[sort_idx[SYM_W-2:0]];
    advance   = (state == ST_BITS) && (!hit || out_free);
    last      = (bit_idx == LAST_BIT);
    close_go  = (state == ST_CLOSE) && out_free;
    out_load  = (advance && hit) || close_go;
    q_pop     = q_valid && ((state == ST_IDLE) ||
                            (advance && last && !cur.final_flag) ||
                            close_go);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      bit_idx   <= '0;
      code_acc  <= '0;
      code_len  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur <= q_item;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_BITS;
          end
        end
        ST_BITS: begin
          if (advance) begin
            if (hit) begin
              symbol        <= hit_sym;
              symbol_valid  <= 1'b1;
              end_of_string <= 1'b0;
              leftover_bits <= '0;
              code_acc      <= '0;
              code_len      <= '0;
            end else begin
              code_acc <= code_next;
              code_len <= len_next;
            end
            bit_idx <= bit_idx + 3'd1;
            if (last) begin
              if (cur.final_flag) begin
                state <= ST_CLOSE;
              end else if (!q_valid) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_CLOSE: begin
          if (close_go) begin
            // closing item reports the unfinished code as padding
            symbol        <= '0;
            symbol_valid  <= 1'b0;
            end_of_string <= 1'b1;
            leftover_bits <= code_len;
            code_acc      <= '0;
            code_len      <= '0;
            state         <= q_valid ? ST_BITS : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
